// File: rtl/skvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skvs_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MAX_BYTES  = 16;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    localparam logic [1:0] OP_STORE  = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_FORGET = 2'd2;

    localparam logic [2:0] ST_STORED    = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EXISTS    = 3'd3;
    localparam logic [2:0] ST_NO_SPACE  = 3'd4;
    localparam logic [2:0] ST_FORGOTTEN = 3'd5;

    // One key or one value: length and up to 16 bytes, byte 0 lowest.
    typedef struct packed {
        logic [4:0]  len;
        logic [63:0] high;
        logic [63:0] low;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Saturate the length and zero every byte past it.
    function automatic entry_t norm_entry(
        input logic [63:0] word_low,
        input logic [63:0] word_high,
        input logic [4:0]  len
    );
        entry_t     e;
        logic [4:0] n;
        n     = (len > 5'(MAX_BYTES)) ? 5'(MAX_BYTES) : len;
        e.len = n;
        for (int b = 0; b < 8; b++)
        begin
            e.low[8*b +: 8]  = (5'(b) < n)     ? word_low[8*b +: 8]  : 8'h00;
            e.high[8*b +: 8] = (5'(b + 8) < n) ? word_high[8*b +: 8] : 8'h00;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

// File: rtl/skvs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module skvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                                        clk,
    input  wire logic                                        wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/slotted_key_value_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake                Payload
// in       in_valid / in_ready      operation, key_*, value_*
// out      out_valid / out_ready    status, slot_index, found_value_*
//
// Each command scans all SLOT_COUNT key entries, one read a cycle from the
// key RAM, then decides; a store into a free slot writes both RAMs, and a
// lookup that hits makes a second read from the value RAM. The scan is
// the bound on rate; a new command is taken once the previous one has
// reached the output register, which may still be waiting.
// Reset clears all used marks at once; key and value RAMs are not cleared.

module slotted_key_value_store (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  operation,
    input  wire logic [63:0] key_low,
    input  wire logic [63:0] key_high,
    input  wire logic [4:0]  key_length,
    input  wire logic [63:0] value_low,
    input  wire logic [63:0] value_high,
    input  wire logic [4:0]  value_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic      [2:0]  status,
    output logic      [4:0]  slot_index,
    output logic      [63:0] found_value_low,
    output logic      [63:0] found_value_high,
    output logic      [4:0]  found_value_length
);

    import skvs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_VREAD,
        S_VWAIT,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [1:0]          op_reg;
    entry_t              key_reg;
    entry_t              val_reg;
    logic [SLOT_COUNT-1:0] used_reg;

    logic [IDX_W-1:0]    issue_idx_reg;
    logic                issuing_reg;
    logic                cmp_vld_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;
    logic                hit_reg;
    logic [IDX_W-1:0]    hit_idx_reg;
    logic                free_reg;
    logic [IDX_W-1:0]    free_idx_reg;

    logic [2:0]          res_status_reg;
    logic [4:0]          res_slot_reg;
    entry_t              res_val_reg;

    logic                out_valid_reg;
    logic [2:0]          status_reg;
    logic [4:0]          slot_index_reg;
    entry_t              found_reg;

    entry_t              key_in;
    entry_t              val_in;
    entry_t              key_rd;
    entry_t              val_rd;
    logic                in_xfer;
    logic                key_rd_en;
    logic                val_rd_en;
    logic                wr_en;
    logic                key_match;

    assign key_in    = norm_entry(key_low, key_high, key_length);
    assign val_in    = norm_entry(value_low, value_high, value_length);
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign key_rd_en = (state_reg == S_SCAN) && issuing_reg;
    assign val_rd_en = (state_reg == S_VREAD);
    assign wr_en     = (state_reg == S_DECIDE) && (op_reg == OP_STORE)
                       && !hit_reg && free_reg;
    assign key_match = used_reg[cmp_idx_reg] && (key_rd == key_reg);

    skvs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (key_reg),
        .rd_en   (key_rd_en),
        .rd_addr (issue_idx_reg),
        .rd_data (key_rd)
    );

    skvs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_val_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (free_idx_reg),
        .wr_data (val_reg),
        .rd_en   (val_rd_en),
        .rd_addr (hit_idx_reg),
        .rd_data (val_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= OP_STORE;
            key_reg        <= '0;
            val_reg        <= '0;
            used_reg       <= '0;
            issue_idx_reg  <= '0;
            issuing_reg    <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            res_status_reg <= ST_NOT_FOUND;
            res_slot_reg   <= '0;
            res_val_reg    <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_NOT_FOUND;
            slot_index_reg <= '0;
            found_reg      <= '0;
        end
        else
        begin
            // Drop valid on a transfer unless a new result is loaded this cycle.
            if (out_valid_reg && out_ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        op_reg        <= operation;
                        key_reg       <= key_in;
                        val_reg       <= val_in;
                        issue_idx_reg <= '0;
                        issuing_reg   <= 1'b1;
                        cmp_vld_reg   <= 1'b0;
                        hit_reg       <= 1'b0;
                        free_reg      <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                end

                S_SCAN:
                begin
                    // Issue reads; compare the entry whose read was issued in the previous cycle.
                    cmp_vld_reg <= issuing_reg;
                    cmp_idx_reg <= issue_idx_reg;
                    if (issuing_reg)
                    begin
                        if (issue_idx_reg == LAST_IDX)
                        begin
                            issuing_reg <= 1'b0;
                        end
                        else
                        begin
                            issue_idx_reg <= issue_idx_reg + IDX_W'(1);
                        end
                    end
                    if (cmp_vld_reg)
                    begin
                        if (key_match && !hit_reg)
                        begin
                            hit_reg     <= 1'b1;
                            hit_idx_reg <= cmp_idx_reg;
                        end
                        if (!used_reg[cmp_idx_reg] && !free_reg)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= cmp_idx_reg;
                        end
                        if (cmp_idx_reg == LAST_IDX)
                        begin
                            state_reg <= S_DECIDE;
                        end
                    end
                end

                S_DECIDE:
                begin
                    unique case (op_reg)
                        OP_STORE:
                        begin
                            res_val_reg <= '0;
                            state_reg   <= S_DONE;
                            if (hit_reg)
                            begin
                                res_status_reg <= ST_EXISTS;
                                res_slot_reg   <= '0;
                            end
                            else if (free_reg)
                            begin
                                used_reg[free_idx_reg] <= 1'b1;
                                res_status_reg         <= ST_STORED;
                                res_slot_reg           <= 5'(free_idx_reg);
                            end
                            else
                            begin
                                res_status_reg <= ST_NO_SPACE;
                                res_slot_reg   <= '0;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            if (hit_reg)
                            begin
                                state_reg <= S_VREAD;
                            end
                            else
                            begin
                                res_status_reg <= ST_NOT_FOUND;
                                res_slot_reg   <= '0;
                                res_val_reg    <= '0;
                                state_reg      <= S_DONE;
                            end
                        end
                        OP_FORGET:
                        begin
                            res_val_reg <= '0;
                            state_reg   <= S_DONE;
                            if (hit_reg)
                            begin
                                used_reg[hit_idx_reg] <= 1'b0;
                                res_status_reg        <= ST_FORGOTTEN;
                                res_slot_reg          <= 5'(hit_idx_reg);
                            end
                            else
                            begin
                                res_status_reg <= ST_NOT_FOUND;
                                res_slot_reg   <= '0;
                            end
                        end
                        default:
                        begin
                            res_status_reg <= ST_NOT_FOUND;
                            res_slot_reg   <= '0;
                            res_val_reg    <= '0;
                            state_reg      <= S_DONE;
                        end
                    endcase
                end

                S_VREAD:
                begin
                    state_reg <= S_VWAIT;
                end

                S_VWAIT:
                begin
                    res_status_reg <= ST_FOUND;
                    res_slot_reg   <= 5'(hit_idx_reg);
                    res_val_reg    <= val_rd;
                    state_reg      <= S_DONE;
                end

                S_DONE:
                begin
                    // Hold until the output register is free or being drained.
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        status_reg     <= res_status_reg;
                        slot_index_reg <= res_slot_reg;
                        found_reg      <= res_val_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign slot_index         = slot_index_reg;
    assign found_value_low    = found_reg.low;
    assign found_value_high   = found_reg.high;
    assign found_value_length = found_reg.len;

endmodule

`default_nettype wire

// File: test/slotted_key_value_store_tb.sv
`timescale 1ns / 1ps

module slotted_key_value_store_tb;

    import skvs_pkg::*;

    localparam logic [1:0] OP_UNKNOWN   = 2'd3;
    localparam int         KEY_POOL     = 48;
    localparam int         RANDOM_ITEMS = 1830;
    localparam int         PHASE_ITEMS  = 150;
    localparam int         LONG_HOLD    = 400;
    localparam int         DRAIN_CYCLES = 2 * SLOT_COUNT + 16;
    localparam int         CYCLE_LIMIT  = 2000000;
    localparam logic [63:0] ONES        = '1;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  slot;
        logic [63:0] value_low;
        logic [63:0] value_high;
        logic [4:0]  value_len;
    } reply_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [63:0] klo;
        logic [63:0] khi;
        logic [4:0]  klen;
        logic [63:0] vlo;
        logic [63:0] vhi;
        logic [4:0]  vlen;
    } command_t;

    class kv_scoreboard;
        bit     used [SLOT_COUNT];
        entry_t keys [SLOT_COUNT];
        entry_t vals [SLOT_COUNT];
        reply_t pending [$];
        int     errors;
        int     commands;
        int     replies;
        int     status_seen [8];

        function logic [127:0] keep_mask(logic [4:0] len);
            int unsigned n;
            n = (len > 5'd16) ? 16 : len;
            if (n == 16)
            begin
                return '1;
            end
            return (128'd1 << (8 * n)) - 128'd1;
        endfunction

        function entry_t trim(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
            entry_t e;
            e.len = (len > 5'd16) ? 5'd16 : len;
            {e.high, e.low} = {hi, lo} & keep_mask(len);
            return e;
        endfunction

        // Predict the reply to one transferred command and update the table.
        function void note_command(command_t c);
            entry_t key;
            entry_t val;
            reply_t r;
            int     hit;
            key = trim(c.klo, c.khi, c.klen);
            val = trim(c.vlo, c.vhi, c.vlen);
            r = '0;
            r.status = ST_NOT_FOUND;
            hit = -1;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                if (hit < 0 && used[i] && keys[i] == key)
                begin
                    hit = i;
                end
            end
            case (c.op)
                OP_STORE:
                begin
                    if (hit >= 0)
                    begin
                        r.status = ST_EXISTS;
                    end
                    else
                    begin
                        r.status = ST_NO_SPACE;
                        for (int i = 0; i < SLOT_COUNT; i++)
                        begin
                            if (r.status == ST_NO_SPACE && !used[i])
                            begin
                                used[i] = 1'b1;
                                keys[i] = key;
                                vals[i] = val;
                                r.status = ST_STORED;
                                r.slot = i[4:0];
                            end
                        end
                    end
                end
                OP_LOOKUP:
                begin
                    if (hit >= 0)
                    begin
                        r.status = ST_FOUND;
                        r.slot = hit[4:0];
                        r.value_low = vals[hit].low;
                        r.value_high = vals[hit].high;
                        r.value_len = vals[hit].len;
                    end
                end
                OP_FORGET:
                begin
                    if (hit >= 0)
                    begin
                        used[hit] = 1'b0;
                        r.status = ST_FORGOTTEN;
                        r.slot = hit[4:0];
                    end
                end
                default:
                begin
                end
            endcase
            pending.push_back(r);
            status_seen[r.status]++;
            commands++;
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(reply_t got);
            reply_t want;
            replies++;
            if (pending.size() == 0)
            begin
                $display("%0t: reply with nothing outstanding, status %0d slot %0d",
                         $time, got.status, got.slot);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("slot_index", 64'(want.slot), 64'(got.slot));
            compare_field("found_value_low", want.value_low, got.value_low);
            compare_field("found_value_high", want.value_high, got.value_high);
            compare_field("found_value_length", 64'(want.value_len), 64'(got.value_len));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  operation;
    logic [63:0] key_low;
    logic [63:0] key_high;
    logic [4:0]  key_length;
    logic [63:0] value_low;
    logic [63:0] value_high;
    logic [4:0]  value_length;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  status;
    logic [4:0]  slot_index;
    logic [63:0] found_value_low;
    logic [63:0] found_value_high;
    logic [4:0]  found_value_length;

    kv_scoreboard sb = new();
    int           cycle_count = 0;

    logic [63:0] pool_lo  [KEY_POOL];
    logic [63:0] pool_hi  [KEY_POOL];
    logic [4:0]  pool_len [KEY_POOL];

    slotted_key_value_store dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .operation          (operation),
        .key_low            (key_low),
        .key_high           (key_high),
        .key_length         (key_length),
        .value_low          (value_low),
        .value_high         (value_high),
        .value_length       (value_length),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .slot_index         (slot_index),
        .found_value_low    (found_value_low),
        .found_value_high   (found_value_high),
        .found_value_length (found_value_length)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycle_count, sb.pending.size());
            $display("slotted_key_value_store test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            sb.note_command('{operation, key_low, key_high, key_length,
                              value_low, value_high, value_length});
        end
        if (rst_n && out_valid && out_ready)
        begin
            sb.check_result('{status, slot_index, found_value_low,
                              found_value_high, found_value_length});
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic command_t make_command(logic [1:0] op, logic [63:0] klo,
                                              logic [63:0] khi, logic [4:0] klen,
                                              logic [63:0] vlo, logic [63:0] vhi,
                                              logic [4:0] vlen);
        command_t c;
        c = '{op, klo, khi, klen, vlo, vhi, vlen};
        return c;
    endfunction

    // Every third key shares its bytes with a common base so that length decides.
    function automatic void refresh_key_pool();
        logic [63:0] base_lo;
        logic [63:0] base_hi;
        base_lo = rand64();
        base_hi = rand64();
        for (int i = 0; i < KEY_POOL; i++)
        begin
            pool_lo[i] = (i % 3 == 0) ? base_lo : rand64();
            pool_hi[i] = (i % 3 == 0) ? base_hi : rand64();
            pool_len[i] = 5'($urandom_range(0, 16));
        end
    endfunction

    function automatic command_t random_command(int store_pct, int forget_pct);
        command_t     c;
        int           pick;
        int           r;
        logic [127:0] mask;
        logic [127:0] noise;
        r = $urandom_range(0, 99);
        if (r < store_pct)
            c.op = OP_STORE;
        else if (r < store_pct + forget_pct)
            c.op = OP_FORGET;
        else if (r < 97)
            c.op = OP_LOOKUP;
        else
            c.op = OP_UNKNOWN;
        noise = {rand64(), rand64()};
        if ($urandom_range(0, 9) == 0)
        begin
            {c.khi, c.klo} = noise;
            c.klen = 5'($urandom_range(0, 31));
        end
        else
        begin
            // Reuse a pool key, with fresh junk past its length.
            pick = $urandom_range(0, KEY_POOL - 1);
            c.klen = pool_len[pick];
            if (c.klen == 5'd16 && $urandom_range(0, 1) == 1)
                c.klen = 5'($urandom_range(16, 31));
            mask = sb.keep_mask(c.klen);
            {c.khi, c.klo} = ({pool_hi[pick], pool_lo[pick]} & mask) | (noise & ~mask);
        end
        c.vlo = rand64();
        c.vhi = rand64();
        c.vlen = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                             : 5'($urandom_range(0, 16));
        return c;
    endfunction

    // Call at a falling edge; returns at the falling edge after the transfer,
    // with valid still high.
    task automatic offer(command_t c);
        in_valid     <= 1'b1;
        operation    <= c.op;
        key_low      <= c.klo;
        key_high     <= c.khi;
        key_length   <= c.klen;
        value_low    <= c.vlo;
        value_high   <= c.vhi;
        value_length <= c.vlen;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic wait_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin : receiver
        int mode;
        int stretch;
        bit long_hold_done;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            stretch = $urandom_range(20, 200);
            repeat (stretch)
            begin
                @(negedge clk);
                if (!long_hold_done && sb.replies >= 300)
                begin
                    // Hold off long enough for the block to back up its input.
                    long_hold_done = 1'b1;
                    out_ready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge clk);
                end
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: out_ready <= ($urandom_range(0, 9) != 0);
                    default: out_ready <= ($urandom_range(0, 9) == 0);
                endcase
            end
        end
    end

    initial
    begin : sender
        int  sent;
        int  burst;
        int  gap;
        bit  store_heavy;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        operation    = OP_STORE;
        key_low      = '0;
        key_high     = '0;
        key_length   = '0;
        value_low    = '0;
        value_high   = '0;
        value_length = '0;
        out_ready    = 1'b0;
        store_heavy  = 1'b0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty table, empty key, saturated lengths, junk past the
        // length, unknown operation, reuse of the lowest freed slot.
        offer(make_command(OP_LOOKUP, ONES, ONES, 5'd0, ONES, ONES, 5'd16));
        offer(make_command(OP_FORGET, 64'h0102030405, '0, 5'd5, '0, '0, 5'd0));
        offer(make_command(OP_UNKNOWN, '0, '0, 5'd0, '0, '0, 5'd0));
        offer(make_command(OP_STORE, ONES, ONES, 5'd0, ONES, ONES, 5'd0));
        offer(make_command(OP_STORE, '0, '0, 5'd0, '0, '0, 5'd3));
        offer(make_command(OP_LOOKUP, rand64(), rand64(), 5'd0, '0, '0, 5'd0));
        offer(make_command(OP_STORE, ONES, ONES, 5'd16, ONES, ONES, 5'd16));
        offer(make_command(OP_LOOKUP, ONES, ONES, 5'd31, '0, '0, 5'd0));
        offer(make_command(OP_STORE, ONES, ONES, 5'd31, '0, '0, 5'd1));
        offer(make_command(OP_STORE, '0, '0, 5'd16, '0, '0, 5'd16));
        offer(make_command(OP_STORE, ONES, ONES, 5'd8, ONES, ONES, 5'd31));
        offer(make_command(OP_STORE, ONES, ONES, 5'd9, rand64(), rand64(), 5'd12));
        offer(make_command(OP_LOOKUP, ONES, '0, 5'd8, '0, '0, 5'd0));
        offer(make_command(OP_UNKNOWN, ONES, ONES, 5'd16, ONES, ONES, 5'd16));
        offer(make_command(OP_FORGET, '0, '0, 5'd0, '0, '0, 5'd0));
        offer(make_command(OP_LOOKUP, '0, '0, 5'd0, '0, '0, 5'd0));
        offer(make_command(OP_FORGET, ONES, ONES, 5'd0, '0, '0, 5'd0));
        offer(make_command(OP_STORE, 64'h1234, '0, 5'd2, 64'h5a, '0, 5'd1));
        offer(make_command(OP_LOOKUP, 64'hffff_1234, ONES, 5'd2, '0, '0, 5'd0));
        offer(make_command(OP_FORGET, ONES, ONES, 5'd16, '0, '0, 5'd0));
        offer(make_command(OP_LOOKUP, ONES, ONES, 5'd16, '0, '0, 5'd0));
        wait_until_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && sent < RANDOM_ITEMS)
            begin
                if (sent % PHASE_ITEMS == 0)
                begin
                    // Alternate filling the table with draining it.
                    store_heavy = ~store_heavy;
                    if ($urandom_range(0, 2) != 0)
                        refresh_key_pool();
                end
                if (sent == RANDOM_ITEMS / 2)
                    wait_until_drained();
                if (store_heavy)
                    offer(random_command(60, 10));
                else
                    offer(random_command(30, 35));
                sent++;
                burst--;
            end
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 60);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("%0d commands, %0d replies: %0d stored, %0d found, %0d not found",
                 sb.commands, sb.replies, sb.status_seen[ST_STORED],
                 sb.status_seen[ST_FOUND], sb.status_seen[ST_NOT_FOUND]);
        $display("%0d already present, %0d refused on a full table, %0d forgotten, %0d errors",
                 sb.status_seen[ST_EXISTS], sb.status_seen[ST_NO_SPACE],
                 sb.status_seen[ST_FORGOTTEN], sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("slotted_key_value_store test passed");
        end
        else
        begin
            $display("slotted_key_value_store test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/skvs_pkg.sv
rtl/skvs_ram.sv
rtl/slotted_key_value_store.sv
test/slotted_key_value_store_tb.sv
